// File: hw/rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the 3x3 local binary pattern pixel stream.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Field widths
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned OUT_COL_W = 10;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned HEIGHT_W = 12;
    // Common width for row/column arithmetic (holds 4096 and a carry)
    localparam int unsigned CMP_W    = 13;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

    // Register reset values and minimum frame size
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [CMP_W-1:0]    MIN_DIM    = 13'd3;

    // Code bit positions
    localparam int unsigned BIT_UL = 0;
    localparam int unsigned BIT_U  = 1;
    localparam int unsigned BIT_UR = 2;
    localparam int unsigned BIT_L  = 3;
    localparam int unsigned BIT_R  = 4;
    localparam int unsigned BIT_LL = 5;
    localparam int unsigned BIT_LO = 6;
    localparam int unsigned BIT_LR = 7;

    // Input item
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_in;

    // Result item
    typedef struct packed {
        logic [PIX_W-1:0]     lbp_code;
        logic [ROW_W-1:0]     center_row;
        logic [OUT_COL_W-1:0] center_column;
        logic                 last_of_frame;
    } t_lbp_out;

endpackage

// File: hw/rtl/lbp_3x3_pixel_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pixel_stream
// 3x3 local binary pattern over a raster pixel stream, two rows held in one
// line memory and the last two window columns in registers.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+--------------------
//  in       | to block  | i_in_valid / o_in_stall     | i_in_data (t_pix_in)
//  out      | from blk  | o_out_valid / i_out_stall   | o_out_data (t_lbp_out)
//  cfg      | to block  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One pixel per cycle sustained while the output is not stalled. A pixel is
//  taken in and its line memory read issued at once; from stage 1 the code is
//  formed and the memory written back, and the code goes to the output register.
//  The line memory port (one read, one write per pixel) sets the rate; a
//  same-column read and write in one cycle is forwarded.
//  Synchronous active-low reset clears counters, window and valid flags and
//  loads the frame size defaults 640x480; the line memory is not cleared.
//  o_in_stall is high and o_cfg_ready low while reset is held.
//  A stalled output holds one result and one pixel in flight before
//  o_in_stall rises.
// ----------------------------------------------------------------------------
module lbp_3x3_pixel_stream #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lbp_pkg::t_pix_in                  i_in_data,
    // code output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lbp_pkg::t_lbp_out                 o_out_data,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lbp_pkg::*;

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

    // Configuration registers
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IDX_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size
    logic [CMP_W-1:0] w_eff, h_eff, w_raw, h_raw;

    always_comb begin
        w_raw = CMP_W'(r_width);
        h_raw = CMP_W'(r_height);
        if (w_raw < MIN_DIM)      w_eff = MIN_DIM;
        else if (w_raw > MAX_W_C) w_eff = MAX_W_C;
        else                      w_eff = w_raw;
        h_eff = (h_raw < MIN_DIM) ? MIN_DIM : h_raw;
    end

    // Stage 1 holding register and handshake
    logic                 r_s1_valid;
    logic [PIX_W-1:0]     r_s1_pixel;
    logic [CW-1:0]        r_s1_col;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    logic [ROW_W-1:0]     r_s1_crow;
    logic [OUT_COL_W-1:0] r_s1_ccol;

    logic     r_out_valid;
    t_lbp_out r_out_data;

    logic s1_fire, in_accept;

    assign s1_fire    = r_s1_valid && (!r_s1_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_s1_valid && !s1_fire);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Position counters, advanced when a pixel is taken
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CMP_W-1:0] col_cur, row_cur, col_inc, row_inc;
    logic [CMP_W-1:0] col_m1, row_m1;
    logic             emit_cur, last_cur;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    always_comb begin
        col_cur  = i_in_data.frame_start ? '0 : CMP_W'(r_col);
        row_cur  = i_in_data.frame_start ? '0 : CMP_W'(r_row);
        col_inc  = col_cur + CMP_W'(1);
        row_inc  = row_cur + CMP_W'(1);
        col_m1   = col_cur - CMP_W'(1);
        row_m1   = row_cur - CMP_W'(1);
        emit_cur = (row_cur >= CMP_W'(2)) && (col_cur >= CMP_W'(2));
        last_cur = (row_inc == h_eff) && (col_inc == w_eff);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = row_cur[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel <= i_in_data.pixel;
            r_s1_col   <= col_cur[CW-1:0];
            r_s1_emit  <= emit_cur;
            r_s1_last  <= last_cur;
            r_s1_crow  <= row_m1[ROW_W-1:0];
            r_s1_ccol  <= col_m1[OUT_COL_W-1:0];
        end
    end

    // Line memory: {upper, middle} per column, read-first, registered read
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] wr_data;
    logic [PIX_W-1:0]   top, mid;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_line_mem[col_cur[CW-1:0]];
        end
        if (s1_fire) begin
            r_line_mem[r_s1_col] <= wr_data;
        end
    end

    // Same-column write in the read cycle: keep the written value
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_hit  <= s1_fire && (r_s1_col == col_cur[CW-1:0]);
            r_fwd_data <= wr_data;
        end
    end

    assign {top, mid} = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign wr_data    = {mid, r_s1_pixel};

    // Window registers: w0..w2 older column, w3..w5 newer column
    logic [PIX_W-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pixel;
        end
    end

    // Neighbour-below-centre compare
    logic [PIX_W-1:0] code;

    always_comb begin
        code         = '0;
        code[BIT_UL] = r_win[0] < r_win[4];
        code[BIT_U]  = r_win[3] < r_win[4];
        code[BIT_UR] = top      < r_win[4];
        code[BIT_L]  = r_win[1] < r_win[4];
        code[BIT_R]  = mid      < r_win[4];
        code[BIT_LL] = r_win[2] < r_win[4];
        code[BIT_LO] = r_win[5] < r_win[4];
        code[BIT_LR] = r_s1_pixel < r_win[4];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_data.lbp_code      <= code;
            r_out_data.center_row    <= r_s1_crow;
            r_out_data.center_column <= r_s1_ccol;
            r_out_data.last_of_frame <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: bench/tb_lbp_3x3_pixel_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 local binary pattern pixel stream. A queue
// of pixels feeds a bursty driver. A line-store and window predictor works out
// the code of every interior centre, and a monitor stalls the output on a
// pattern of its own and checks each code in order, field by field. Frame
// sizes change between phases, including extremes and a mid-frame shrink.
// ----------------------------------------------------------------------------
module tb;

    import lbp_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 200;
    localparam int TIMEOUT_NS    = 5_000_000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_pix_in               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_lbp_out              o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Pixels waiting to be sent, codes waiting to come out
    t_pix_in  pixel_queue [$];
    t_lbp_out code_queue [$];
    int       mismatch_count = 0;

    // Predictor state: frame size, counters, line stores and window
    int             cfg_width;
    int             cfg_height;
    int             col_cnt;
    int             row_cnt;
    bit [PIX_W-1:0] upper_line [LINE_DEPTH];
    bit [PIX_W-1:0] middle_line [LINE_DEPTH];
    bit [PIX_W-1:0] window_pix [6];

    // Sender and receiver pacing
    int burst_left = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int stall_pct  = 0;

    lbp_3x3_pixel_stream #(
        .MAX_WIDTH(LINE_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_width(input int w);
        if (w < 3) return 3;
        if (w > LINE_DEPTH) return LINE_DEPTH;
        return w;
    endfunction

    function automatic int eff_height(input int h);
        return (h < 3) ? 3 : h;
    endfunction

    // One pixel through the line stores and window; queues a code when the
    // window around (row-1, col-1) is complete
    task automatic predict_code(input t_pix_in px);
        int             w, h, col, row;
        bit [PIX_W-1:0] top, mid, ctr;
        t_lbp_out       res;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        if (px.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        col = (col_cnt >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_cnt;
        row = row_cnt;
        top = upper_line[col];
        mid = middle_line[col];
        if (row >= 2 && col >= 2) begin
            ctr                  = window_pix[4];
            res.lbp_code         = '0;
            res.lbp_code[BIT_UL] = window_pix[0] < ctr;
            res.lbp_code[BIT_U]  = window_pix[3] < ctr;
            res.lbp_code[BIT_UR] = top < ctr;
            res.lbp_code[BIT_L]  = window_pix[1] < ctr;
            res.lbp_code[BIT_R]  = mid < ctr;
            res.lbp_code[BIT_LL] = window_pix[2] < ctr;
            res.lbp_code[BIT_LO] = window_pix[5] < ctr;
            res.lbp_code[BIT_LR] = px.pixel < ctr;
            res.center_row       = ROW_W'(row - 1);
            res.center_column    = OUT_COL_W'(col - 1);
            res.last_of_frame    = (row + 1 == h) && (col + 1 == w);
            code_queue.push_back(res);
        end
        upper_line[col]  = mid;
        middle_line[col] = px.pixel;
        window_pix[0] = window_pix[3];
        window_pix[1] = window_pix[4];
        window_pix[2] = window_pix[5];
        window_pix[3] = top;
        window_pix[4] = mid;
        window_pix[5] = px.pixel;
        // advance raster position, wrapping at row and frame end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_cnt = col;
        row_cnt = row;
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Predictor: follows every accepted pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = WIDTH_RST;
            cfg_height = HEIGHT_RST;
            col_cnt    = 0;
            row_cnt    = 0;
            foreach (window_pix[k]) window_pix[k] = '0;
        end else if (i_in_valid && !o_in_stall) begin
            predict_code(i_in_data);
        end
    end

    // Driver: bursts of random length with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                i_in_data  <= pixel_queue.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall pattern in stretches, check each accepted code
    always @(posedge i_clk) begin
        t_lbp_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (code_queue.size() == 0) begin
                    $display("%0t: code with none expected: expected none actual %h",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = code_queue.pop_front();
                    compare_field("lbp_code", want.lbp_code, o_out_data.lbp_code);
                    compare_field("center_row", want.center_row, o_out_data.center_row);
                    compare_field("center_column", want.center_column,
                                  o_out_data.center_column);
                    compare_field("last_of_frame", want.last_of_frame,
                                  o_out_data.last_of_frame);
                end
            end
            if (stall_left == 0) begin
                stall_left = $urandom_range(1, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            stall_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_WIDTH) cfg_width = data[WIDTH_W-1:0];
        else cfg_height = data[HEIGHT_W-1:0];
    endtask

    // Everything sent and every code back, then a quiet settling wait
    task automatic wait_idle();
        @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid || code_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic start_phase(input int w_val, input int h_val);
        wait_idle();
        write_reg(CFG_IDX_WIDTH, CFG_DATA_W'(w_val));
        write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'(h_val));
        @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel(input int style);
        case (style)
            0: return PIX_W'($urandom_range(0, 255));
            // narrow range, lots of ties with the centre
            1: return PIX_W'($urandom_range(120, 123));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd255;
                    2: return 8'd127;
                    default: return 8'd128;
                endcase
            end
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] value, input logic first);
        t_pix_in px;
        px.pixel       = value;
        px.frame_start = first;
        pixel_queue.push_back(px);
    endtask

    // n pixels; optional start mark and optional stray restarts
    task automatic push_frame(input int n, input bit mark, input int style, input bit noisy);
        for (int i = 0; i < n; i++)
            push_pixel(draw_pixel(style),
                       (i == 0 && mark) || (noisy && i != 0 && $urandom_range(0, 59) == 0));
    endtask

    initial begin
        byte unsigned directed_pix [27];
        int           w_val, h_val, n, frame_px, frames, style;
        int           random_items;
        bit           keep_going, prev_full, mark, noisy;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes below the minimum act as 3x3. First frame marked, the next
        // two follow by wrap-around alone: mixed, all-above and all-below
        directed_pix = '{8'd0,   8'd128, 8'd255, 8'd127, 8'd128, 8'd129,
                         8'd128, 8'd0,   8'd255,
                         8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255,
                         8'd255, 8'd255, 8'd255,
                         8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,
                         8'd0,   8'd0,   8'd0};
        start_phase(0, 1);
        foreach (directed_pix[k]) push_pixel(directed_pix[k], k == 0);

        // Tallest frame, first rows only
        start_phase(3, 4095);
        push_frame(150, 1'b1, 0, 1'b0);

        // Frame shrinks in width and height part way through
        start_phase(12, 9);
        push_frame(70, 1'b1, 0, 1'b0);
        start_phase(7, 4);
        push_frame(30, 1'b0, 0, 1'b0);

        // Random phases: mostly whole frames, some cut short or with restarts
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w_val = $urandom_range(0, 2);
                1, 2: w_val = $urandom_range(17, 40);
                default: w_val = $urandom_range(3, 16);
            endcase
            h_val = (eff_width(w_val) > 16) ? $urandom_range(0, 5) : $urandom_range(0, 12);
            // carry on the open frame only when the width does not grow
            keep_going = ($urandom_range(0, 4) == 0) &&
                         (eff_width(w_val) <= eff_width(cfg_width));
            start_phase(w_val, h_val);
            if (keep_going) begin
                n = $urandom_range(5, 40);
                push_frame(n, 1'b0, 0, 1'b0);
                random_items += n;
            end
            frame_px  = eff_width(w_val) * eff_height(h_val);
            frames    = $urandom_range(1, 3);
            prev_full = 1'b0;
            for (int f = 0; f < frames; f++) begin
                n     = ($urandom_range(0, 5) == 0) ? $urandom_range(1, frame_px) : frame_px;
                mark  = !(prev_full && $urandom_range(0, 2) == 0);
                noisy = ($urandom_range(0, 3) == 0);
                style = $urandom_range(0, 2);
                push_frame(n, mark, style, noisy);
                prev_full = (n == frame_px) && !noisy;
                random_items += n;
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("[lbp_3x3_pixel_stream] OK");
        end else begin
            $display("[lbp_3x3_pixel_stream] ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("[lbp_3x3_pixel_stream] ERROR");
        $finish;
    end

endmodule
